/* design/tplr_pkg.sv */
package tplr_pkg;

	localparam int MaxEntries = 253;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);

	typedef enum logic [1:0] {
		RK_POINT   = 2'd0,
		RK_DONE    = 2'd1,
		RK_LOST    = 2'd2,
		RK_SKIPPED = 2'd3
	} rkind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONE     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_RATE     = 2'd0,
		REG_X_OFFSET = 2'd1,
		REG_Y_OFFSET = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic        kind;
		logic        overflow_in;
		logic        field_in;
		logic [15:0] mem_word;
		logic        hor_lsb;
	} item_t;

	typedef struct packed {
		rkind_t      result_kind;
		logic [7:0]  x_pos;
		logic [7:0]  y_pos;
		logic [7:0]  point_count;
		status_t     status;
		logic        interlace_field;
		logic        diode_select;
		logic [31:0] lost_fields;
		logic        last_of_run;
	} result_t;

	// up to two results produced by one item, slot 0 first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [7:0] rate;
		logic [7:0] x_offset;
		logic [7:0] y_offset;
		logic       rate_wr;
	} cfg_t;

endpackage

/* design/tracker_point_list_reader_unit.sv */
// Tracker point list reader. Sync events (tuser 0) pick sampled or skipped
// fields from the rate register; memory words (tuser 1) of a sampled field are
// decoded into corrected points, dropped when x leaves 0..255. Each input item
// passes one input register, then combinational decode into a 4-entry result
// queue; an item is accepted every cycle while the queue has two free slots.
// Results leave at one per cycle while m_axis_tready is high, so an item giving
// two results (a kept point on the last entry) can hold back the input side.
// Items reach tvalid via input register and queue; configuration is always ready.
module tracker_point_list_reader_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // overflow_in, field_in, mem_word[15:0], hor_lsb, pad
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // x_pos, y_pos, point_count, status, interlace_field,
	                                   // diode_select, lost_fields[31:0], pad
	output logic [1:0]  m_axis_tuser,  // result_kind
	output logic        m_axis_tlast
);
	import tplr_pkg::*;

	logic [7:0] rate_q, xoff_q, yoff_q;
	logic       cfg_wr;
	cfg_t       cfg;
	item_t      item;
	push_t      push;
	logic       room;
	result_t    res;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 8'd1;
			xoff_q <= 8'd28;
			yoff_q <= 8'd2;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_RATE:     rate_q <= cfg_data;
				REG_X_OFFSET: xoff_q <= cfg_data;
				REG_Y_OFFSET: yoff_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign cfg = '{rate: rate_q, x_offset: xoff_q, y_offset: yoff_q,
		rate_wr: cfg_wr && (cfg_index == REG_RATE)};

	assign item = '{kind: s_axis_tuser, overflow_in: s_axis_tdata[0],
		field_in: s_axis_tdata[1], mem_word: s_axis_tdata[17:2],
		hor_lsb: s_axis_tdata[18]};

	tplr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.room     (room),
		.push     (push)
	);

	tplr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.result_kind;
	assign m_axis_tlast = res.last_of_run;
	assign m_axis_tdata = {4'd0, res.lost_fields, res.diode_select, res.interlace_field,
		res.status, res.point_count, res.y_pos, res.x_pos};

endmodule

/* design/tplr_core.sv */
module tplr_core (
	input  logic           clk,
	input  logic           arst_n,
	input  tplr_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  tplr_pkg::item_t in_item,
	input  logic           room,
	output tplr_pkg::push_t push
);
	import tplr_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        adv;

	logic [7:0]  phase_q;
	logic        active_q;
	logic [7:0]  entry_q;
	logic [7:0]  kept_q;
	logic        ovf_q;
	logic        field_q;
	status_t     fstat_q;
	logic        diode_q;
	logic [31:0] lost_q;

	logic        sampled;
	logic [7:0]  phase_inc;
	logic [9:0]  raw_x;
	logic [7:0]  raw_y;
	logic [9:0]  dx;
	logic        keep;
	logic        list_end;
	logic [7:0]  entry_inc;
	logic [7:0]  kept_inc;
	logic        is_lost;
	status_t     fstat;
	logic        word_act;
	result_t     r_pt, r_lost, r_done, r_skip;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign sampled   = (phase_q == 8'd0);
	assign phase_inc = phase_q + 8'd1;
	assign raw_x     = {1'b0, item_s1.mem_word[15:7]} + {9'd0, item_s1.hor_lsb};
	assign raw_y     = item_s1.mem_word[7:0];
	assign dx        = raw_x - {2'b00, cfg.x_offset};
	assign keep      = (raw_x >= {2'b00, cfg.x_offset}) && (dx[9:8] == 2'b00);
	assign list_end  = (raw_y == 8'd0) && !ovf_q;
	assign entry_inc = entry_q + 8'd1;
	assign kept_inc  = kept_q + 8'd1;
	assign is_lost   = entry_inc >= 8'(MaxEntries);
	assign word_act  = item_s1.kind && active_q;

	always_comb begin
		fstat = fstat_q;
		if (entry_q == 8'd0) begin
			if (ovf_q) begin
				fstat = ST_OVERFLOW;
			end else if (raw_y == 8'd0) begin
				fstat = ST_NONE;
			end else begin
				fstat = ST_OK;
			end
		end
	end

	always_comb begin
		r_pt = '{result_kind: RK_POINT, x_pos: dx[7:0], y_pos: raw_y - cfg.y_offset,
			point_count: kept_inc, status: fstat, interlace_field: field_q,
			diode_select: diode_q, lost_fields: lost_q, last_of_run: !is_lost};
		r_lost = '{result_kind: RK_LOST, x_pos: 8'd0, y_pos: 8'd0,
			point_count: keep ? kept_inc : kept_q, status: fstat,
			interlace_field: field_q, diode_select: diode_q,
			lost_fields: lost_q + 32'd1, last_of_run: 1'b1};
		r_done = '{result_kind: RK_DONE, x_pos: 8'd0, y_pos: 8'd0,
			point_count: kept_q, status: fstat, interlace_field: field_q,
			diode_select: !diode_q, lost_fields: lost_q, last_of_run: 1'b1};
		r_skip = '{result_kind: RK_SKIPPED, x_pos: 8'd0, y_pos: 8'd0,
			point_count: 8'd0, status: ST_OK, interlace_field: field_q,
			diode_select: diode_q, lost_fields: lost_q, last_of_run: 1'b1};
	end

	always_comb begin
		push.n  = 2'd0;
		push.r0 = r_skip;
		push.r1 = r_lost;
		if (adv) begin
			if (!item_s1.kind) begin
				if (!sampled) begin
					push.n = 2'd1;
				end
			end else if (active_q) begin
				if (list_end) begin
					push.n  = 2'd1;
					push.r0 = r_done;
				end else if (keep) begin
					push.n  = is_lost ? 2'd2 : 2'd1;
					push.r0 = r_pt;
				end else if (is_lost) begin
					push.n  = 2'd1;
					push.r0 = r_lost;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 8'd0;
			active_q <= 1'b0;
			entry_q  <= 8'd0;
			kept_q   <= 8'd0;
			ovf_q    <= 1'b0;
			field_q  <= 1'b0;
			fstat_q  <= ST_OK;
			diode_q  <= 1'b0;
			lost_q   <= 32'd0;
		end else if (cfg.rate_wr) begin
			phase_q <= 8'd0;
		end else if (adv) begin
			if (!item_s1.kind) begin
				phase_q <= (phase_inc >= cfg.rate) ? 8'd0 : phase_inc;
				kept_q  <= 8'd0;
				if (sampled) begin
					active_q <= 1'b1;
					entry_q  <= 8'd0;
					ovf_q    <= item_s1.overflow_in;
					field_q  <= item_s1.field_in;
					fstat_q  <= ST_OK;
				end else begin
					active_q <= 1'b0;
				end
			end else if (word_act) begin
				fstat_q <= fstat;
				if (list_end) begin
					active_q <= 1'b0;
					diode_q  <= !diode_q;
				end else begin
					entry_q <= entry_inc;
					if (keep) begin
						kept_q <= kept_inc;
					end
					if (is_lost) begin
						active_q <= 1'b0;
						lost_q   <= lost_q + 32'd1;
					end
				end
			end
		end
	end

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r0.result_kind == RK_POINT && push.r1.result_kind == RK_LOST)
		else $error("two results must be a point followed by a lost field");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd1 |-> push.r0.last_of_run)
		else $error("single result not marked last");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> entry_q < 8'(MaxEntries))
		else $error("entry index ran past the list length");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("results pushed without queue room");

endmodule

/* design/tplr_outq.sv */
module tplr_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  tplr_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output tplr_pkg::result_t out_res
);
	import tplr_pkg::*;

	result_t mem [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= (QPtrW+1)'(QDepth - 2);
	assign out_res   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wp_q + QPtrW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPtrW'(push.n);
			if (pop) begin
				rp_q <= rp_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + (QPtrW+1)'(push.n) - (QPtrW+1)'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QDepth))
		else $error("output queue overfilled");

	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == rp_q + cnt_q[QPtrW-1:0])
		else $error("queue pointers disagree with fill count");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
	import tplr_pkg::*;

	localparam int StallLimit = 2000;
	localparam int ItemTarget = 1550;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_RATE;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 24'd0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	tracker_point_list_reader_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// register copies
	logic [7:0]  rate_cfg = 8'd1;
	logic [7:0]  xoff_cfg = 8'd28;
	logic [7:0]  yoff_cfg = 8'd2;

	// field tracking state
	logic [7:0]  phase_ctr = 8'd0;
	logic        armed = 1'b0;
	logic [7:0]  entry_idx = 8'd0;
	logic [7:0]  kept_cnt = 8'd0;
	logic        ovf_latch = 1'b0;
	logic        fld_latch = 1'b0;
	status_t     first_st = ST_OK;
	logic        diode = 1'b0;
	logic [31:0] lost_cnt = 32'd0;

	result_t     results_due[$];
	int          errors = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          hold_len = 0;
	logic        tx_idle = 1'b1;
	logic        rx_idle = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic emit(input rkind_t k, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] n, input status_t st, input logic last);
		result_t r;
		r.result_kind = k;
		r.x_pos = x;
		r.y_pos = y;
		r.point_count = n;
		r.status = st;
		r.interlace_field = fld_latch;
		r.diode_select = diode;
		r.lost_fields = lost_cnt;
		r.last_of_run = last;
		results_due.push_back(r);
	endtask

	task automatic decode_item(input item_t it);
		logic [7:0] nxt;
		logic [7:0] raw_y;
		int raw_x;
		int xo;
		logic full;
		if (!it.kind) begin
			nxt = phase_ctr + 8'd1;
			if (phase_ctr == 8'd0) begin
				phase_ctr = (nxt >= rate_cfg) ? 8'd0 : nxt;
				armed = 1'b1;
				entry_idx = 8'd0;
				kept_cnt = 8'd0;
				ovf_latch = it.overflow_in;
				fld_latch = it.field_in;
				first_st = ST_OK;
				return;
			end
			phase_ctr = (nxt >= rate_cfg) ? 8'd0 : nxt;
			armed = 1'b0;
			kept_cnt = 8'd0;
			emit(RK_SKIPPED, 8'd0, 8'd0, 8'd0, ST_OK, 1'b1);
			return;
		end
		if (!armed)
			return;
		raw_x = int'(it.mem_word[15:7]) + int'(it.hor_lsb);
		raw_y = it.mem_word[7:0];
		xo = int'(xoff_cfg);
		if (entry_idx == 8'd0)
			first_st = ovf_latch ? ST_OVERFLOW : (raw_y == 8'd0 ? ST_NONE : ST_OK);
		if (raw_y == 8'd0 && !ovf_latch) begin
			armed = 1'b0;
			diode = ~diode;
			emit(RK_DONE, 8'd0, 8'd0, kept_cnt, first_st, 1'b1);
			return;
		end
		entry_idx = entry_idx + 8'd1;
		full = (entry_idx >= 8'(MaxEntries));
		if (raw_x >= xo && raw_x - xo <= 255) begin
			kept_cnt = kept_cnt + 8'd1;
			emit(RK_POINT, 8'(raw_x - xo), raw_y - yoff_cfg, kept_cnt, first_st, !full);
		end
		if (full) begin
			armed = 1'b0;
			lost_cnt = lost_cnt + 32'd1;
			emit(RK_LOST, 8'd0, 8'd0, kept_cnt, first_st, 1'b1);
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			errors++;
			$display("%0t: result with nothing due, expected none actual kind %0d", $time,
				got.result_kind);
			return;
		end
		want = results_due.pop_front();
		cmp_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
		cmp_field("x_pos", 32'(want.x_pos), 32'(got.x_pos));
		cmp_field("y_pos", 32'(want.y_pos), 32'(got.y_pos));
		cmp_field("point_count", 32'(want.point_count), 32'(got.point_count));
		cmp_field("status", 32'(want.status), 32'(got.status));
		cmp_field("interlace_field", 32'(want.interlace_field), 32'(got.interlace_field));
		cmp_field("diode_select", 32'(want.diode_select), 32'(got.diode_select));
		cmp_field("lost_fields", want.lost_fields, got.lost_fields);
		cmp_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
	endtask

	always @(posedge clk) begin : monitor
		item_t it;
		result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_RATE: begin
						rate_cfg = cfg_data;
						phase_ctr = 8'd0;
					end
					REG_X_OFFSET: xoff_cfg = cfg_data;
					REG_Y_OFFSET: yoff_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				it.kind = s_axis_tuser;
				it.overflow_in = s_axis_tdata[0];
				it.field_in = s_axis_tdata[1];
				it.mem_word = s_axis_tdata[17:2];
				it.hor_lsb = s_axis_tdata[18];
				decode_item(it);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.result_kind = rkind_t'(m_axis_tuser);
				got.x_pos = m_axis_tdata[7:0];
				got.y_pos = m_axis_tdata[15:8];
				got.point_count = m_axis_tdata[23:16];
				got.status = status_t'(m_axis_tdata[25:24]);
				got.interlace_field = m_axis_tdata[26];
				got.diode_select = m_axis_tdata[27];
				got.lost_fields = m_axis_tdata[59:28];
				got.last_of_run = m_axis_tlast;
				check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin : result_sink
		int gap;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_len > 0) begin
				gap = hold_len;
				hold_len = 0;
			end else
				gap = rx_idle ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(input item_t it);
		int gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, it.hor_lsb, it.mem_word, it.field_in, it.overflow_in};
		s_axis_tuser <= it.kind;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every due result, then let items with no result clear the pipe
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic item_t sync_item(input logic ovf, input logic fld);
		item_t it;
		it.kind = 1'b0;
		it.overflow_in = ovf;
		it.field_in = fld;
		it.mem_word = 16'($urandom_range(0, 65535));
		it.hor_lsb = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t word_item(input logic [15:0] w, input logic h);
		item_t it;
		it.kind = 1'b1;
		it.overflow_in = 1'($urandom_range(0, 1));
		it.field_in = 1'($urandom_range(0, 1));
		it.mem_word = w;
		it.hor_lsb = h;
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.kind = 1'($urandom_range(0, 1));
		it.overflow_in = 1'($urandom_range(0, 1));
		it.field_in = 1'($urandom_range(0, 1));
		it.mem_word = 16'($urandom_range(0, 65535));
		it.hor_lsb = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// nonzero y; always kept unless wide picks an x anywhere
	function automatic item_t rand_point(input logic wide);
		int raw;
		logic h;
		logic [8:0] x9;
		logic [6:0] y7;
		h = 1'($urandom_range(0, 1));
		if (wide && $urandom_range(0, 7) == 0)
			raw = int'($urandom_range(0, 511));
		else
			raw = int'(xoff_cfg) + int'($urandom_range(0, 255)) - int'(h);
		if (raw < 0)
			raw = 0;
		x9 = raw[8:0];
		y7 = 7'($urandom_range(1, 127));
		return word_item({x9, y7}, h);
	endfunction

	function automatic item_t end_word();
		logic [7:0] xh;
		xh = 8'($urandom_range(0, 255));
		return word_item({xh, 1'b0, 7'd0}, 1'($urandom_range(0, 1)));
	endfunction

	task automatic test_directed();
		send_item(word_item({9'd100, 7'd5}, 1'b0));
		send_item(sync_item(1'b0, 1'b1));
		send_item(word_item({9'd27, 7'd3}, 1'b1));
		send_item(word_item({9'd27, 7'd9}, 1'b0));
		send_item(word_item({9'd283, 7'd1}, 1'b0));
		send_item(word_item({9'd283, 7'd1}, 1'b1));
		send_item(word_item(16'hffff, 1'b1));
		send_item(word_item({9'd30, 7'd1}, 1'b0));
		send_item(word_item({9'd30, 7'd2}, 1'b0));
		send_item(word_item({9'd40, 7'd0}, 1'b1));
		send_item(word_item({9'd41, 7'd7}, 1'b0));
		send_item(sync_item(1'b0, 1'b0));
		send_item(word_item(16'h0000, 1'b0));
		send_item(sync_item(1'b1, 1'b1));
		send_item(word_item({9'd50, 7'd0}, 1'b0));
		send_item(word_item({9'd1, 7'd0}, 1'b0));
		// new sync abandons the open list
		send_item(sync_item(1'b0, 1'b0));
		send_item(word_item({9'd60, 7'd10}, 1'b0));
		send_item(word_item({9'd0, 7'd0}, 1'b0));
		send_item(sync_item(1'b1, 1'b0));
		send_item(word_item(16'hffff, 1'b0));
		send_item(word_item(16'hffff, 1'b1));
		send_item(word_item(16'h0000, 1'b0));
		drain();
	endtask

	task automatic test_full_lists();
		send_item(sync_item(1'b0, 1'($urandom_range(0, 1))));
		repeat (MaxEntries) send_item(rand_point(1'b0));
		send_item(sync_item(1'b1, 1'($urandom_range(0, 1))));
		repeat (MaxEntries - 1) send_item(word_item(16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1))));
		send_item(word_item(16'hffff, 1'b1));
		send_item(sync_item(1'b0, 1'($urandom_range(0, 1))));
		repeat (MaxEntries - 1) send_item(rand_point(1'b1));
		send_item(end_word());
		drain();
	endtask

	task automatic test_registers();
		write_reg(REG_RATE, 8'd3);
		repeat (6) begin
			send_item(sync_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			send_item(rand_point(1'b0));
			send_item(end_word());
		end
		drain();
		write_reg(REG_RATE, 8'd0);
		repeat (4) begin
			send_item(sync_item(1'b0, 1'($urandom_range(0, 1))));
			send_item(rand_point(1'b0));
			send_item(end_word());
		end
		drain();
		write_reg(REG_RATE, 8'd255);
		repeat (12) send_item(sync_item(1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1))));
		drain();
		write_reg(REG_RATE, 8'd255);
		repeat (2) send_item(sync_item(1'b0, 1'b1));
		drain();
		write_reg(REG_RATE, 8'd1);
		write_reg(REG_X_OFFSET, 8'd0);
		write_reg(REG_Y_OFFSET, 8'd0);
		send_item(sync_item(1'b0, 1'b0));
		send_item(word_item({9'd0, 7'd1}, 1'b0));
		send_item(word_item({9'd255, 7'd3}, 1'b0));
		send_item(word_item({9'd255, 7'd3}, 1'b1));
		send_item(end_word());
		drain();
		write_reg(REG_X_OFFSET, 8'd255);
		write_reg(REG_Y_OFFSET, 8'd255);
		send_item(sync_item(1'b0, 1'b1));
		send_item(word_item({9'd255, 7'd4}, 1'b0));
		send_item(word_item({9'd254, 7'd4}, 1'b0));
		send_item(word_item({9'd510, 7'd1}, 1'b0));
		send_item(word_item({9'd510, 7'd1}, 1'b1));
		send_item(word_item(16'hffff, 1'b1));
		send_item(end_word());
		drain();
		write_reg(REG_X_OFFSET, 8'd28);
		write_reg(REG_Y_OFFSET, 8'd2);
	endtask

	task automatic test_pressure();
		tx_idle = 1'b0;
		hold_len = 300;
		send_item(sync_item(1'b0, 1'b1));
		repeat (60) send_item(rand_point(1'b0));
		send_item(end_word());
		drain();
		tx_idle = 1'b1;
	endtask

	task automatic test_random();
		int len;
		int grp;
		logic ovf;
		while (items_sent < ItemTarget) begin
			drain();
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 3))
					0, 1: write_reg(REG_RATE, 8'd1);
					2: write_reg(REG_RATE, 8'($urandom_range(2, 4)));
					default: write_reg(REG_RATE, 8'($urandom_range(0, 255)));
				endcase
			end
			if ($urandom_range(0, 1))
				write_reg(REG_X_OFFSET, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				write_reg(REG_Y_OFFSET, 8'($urandom_range(0, 255)));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			grp = 0;
			while (grp < 20 && items_sent < ItemTarget) begin
				grp++;
				case ($urandom_range(0, 9))
					0: send_item(noise_item());
					1: begin
						// list cut short by the next sync
						send_item(sync_item(1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1))));
						repeat ($urandom_range(1, 4)) send_item(rand_point(1'b1));
					end
					default: begin
						ovf = ($urandom_range(0, 3) == 0);
						send_item(sync_item(ovf, 1'($urandom_range(0, 1))));
						len = ($urandom_range(0, 24) == 0) ? $urandom_range(240, 260)
							: $urandom_range(0, 12);
						repeat (len) begin
							if (ovf && $urandom_range(0, 3) == 0)
								send_item(end_word());
							else
								send_item(rand_point(1'b1));
						end
						if ($urandom_range(0, 7) != 0)
							send_item(end_word());
					end
				endcase
			end
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_lists();
		test_registers();
		test_pressure();
		test_random();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
